// ===== rtl/mie_pkg.sv =====
// Shared types and constants for the modular inverse block.
`default_nettype none

package mie_pkg;

    // Default operand width in bits.
    localparam int unsigned WIDTH_DEF = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_FIX,
        ST_NEG
    } t_state;

    // Operand selection for the shared subtract and compare unit.
    typedef enum logic [1:0] {
        OP_ALIGN,
        OP_SUB,
        OP_FIX,
        OP_NEG
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/mie_unit.sv =====
// Shared subtract and compare unit with its operand selection.
`default_nettype none

module mie_unit #(
    parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
    input  mie_pkg::t_op       i_sel,
    input  logic [WIDTH-1:0]   i_r0,
    input  logic [WIDTH-1:0]   i_rd,
    input  logic [WIDTH-1:0]   i_u0,
    input  logic [WIDTH-1:0]   i_mod,
    output logic [WIDTH-1:0]   o_diff,
    output logic               o_ge
);

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH:0]   diff_ext;

    // The alignment test asks whether the doubled divisor still fits,
    // which is rd <= r0/2 and cannot overflow.
    always_comb begin
        unique case (i_sel)
            mie_pkg::OP_ALIGN: begin
                a = i_r0 >> 1;
                b = i_rd;
            end
            mie_pkg::OP_SUB: begin
                a = i_r0;
                b = i_rd;
            end
            mie_pkg::OP_FIX: begin
                a = i_u0;
                b = i_mod;
            end
            mie_pkg::OP_NEG: begin
                a = i_mod;
                b = i_u0;
            end
            default: begin
                a = i_r0;
                b = i_rd;
            end
        endcase
    end

    assign diff_ext = {1'b0, a} - {1'b0, b};
    assign o_diff   = diff_ext[WIDTH-1:0];
    assign o_ge     = ~diff_ext[WIDTH];

endmodule

`default_nettype wire

// ===== rtl/modular_inverse_extended_euclid_top.sv =====
// Top level of the modular inverse block: sequencer, registers and result port.
`default_nettype none

// Usage.
// An input beat is taken at a rising edge where i_start is high and o_busy is
// low; it carries the modulus m on i_modulus and the value n on
// i_operand_value. The block then runs the extended Euclidean algorithm and
// raises o_busy until the result is out. Each quotient is found by binary
// long division on one shared subtractor: the divisor is first doubled while
// it fits, then walked back down with a conditional subtract per bit, while
// the coefficient is accumulated alongside. A first division by m reduces n
// modulo m with the same hardware. The last division is followed by the final
// correction and the result register.
// A modulus of zero skips the divisions and goes straight to the correction.
// The result beat is o_inverse and o_inverse_exists, shown for exactly one
// cycle with o_valid high. The receiver cannot stall, so the result is never
// held; o_busy is already low during the strobe cycle, so the next input beat
// can be accepted at the edge that ends it.
// Reset (synchronous, active low) returns the sequencer to idle and drops the
// strobe; an item in flight is abandoned.

module modular_inverse_extended_euclid_top #(
    parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_operand_value,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_inverse_exists
);

    localparam int unsigned KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    mie_pkg::t_state r_state, n_state;

    // Remainder pair, the shifted divisor, and the matching coefficients.
    // r_neg is the sign of the coefficient held in r_u0.
    logic [WIDTH-1:0] r_r0, n_r0;
    logic [WIDTH-1:0] r_r1, n_r1;
    logic [WIDTH-1:0] r_rd, n_rd;
    logic [WIDTH-1:0] r_u0, n_u0;
    logic [WIDTH-1:0] r_u1, n_u1;
    logic [WIDTH-1:0] r_ud, n_ud;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [KW-1:0]    r_k, n_k;
    logic             r_neg, n_neg;

    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic             r_ok, n_ok;

    mie_pkg::t_op     op_sel;
    logic [WIDTH-1:0] unit_diff;
    logic             unit_ge;
    logic [WIDTH-1:0] sub_r0;
    logic [WIDTH-1:0] sub_u0;
    logic             gcd_one;

    mie_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .i_sel  (op_sel),
        .i_r0   (r_r0),
        .i_rd   (r_rd),
        .i_u0   (r_u0),
        .i_mod  (r_mod),
        .o_diff (unit_diff),
        .o_ge   (unit_ge)
    );

    // Result of one conditional subtract step of the long division.
    assign sub_r0  = unit_ge ? unit_diff : r_r0;
    assign sub_u0  = unit_ge ? (r_u0 + r_ud) : r_u0;
    assign gcd_one = (r_r0 == WIDTH'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mie_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_rd  <= n_rd;
        r_u0  <= n_u0;
        r_u1  <= n_u1;
        r_ud  <= n_ud;
        r_mod <= n_mod;
        r_k   <= n_k;
        r_neg <= n_neg;
        r_inv <= n_inv;
        r_ok  <= n_ok;
    end

    always_comb begin
        n_state = r_state;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_rd    = r_rd;
        n_u0    = r_u0;
        n_u1    = r_u1;
        n_ud    = r_ud;
        n_mod   = r_mod;
        n_k     = r_k;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_inv   = r_inv;
        n_ok    = r_ok;
        op_sel  = mie_pkg::OP_SUB;

        unique case (r_state)
            mie_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_mod = i_modulus;
                    n_neg = 1'b0;
                    n_k   = '0;
                    if (i_modulus == '0) begin
                        // No inverse exists; the final check sees r0 != 1.
                        n_r0    = '0;
                        n_u0    = '0;
                        n_state = mie_pkg::ST_FIX;
                    end else begin
                        // First division reduces n modulo m. The value carries
                        // coefficient one and the modulus coefficient zero.
                        n_r0    = i_operand_value;
                        n_u0    = WIDTH'(1);
                        n_r1    = i_modulus;
                        n_u1    = '0;
                        n_rd    = i_modulus;
                        n_ud    = '0;
                        n_state = mie_pkg::ST_ALIGN;
                    end
                end
            end
            mie_pkg::ST_ALIGN: begin
                op_sel = mie_pkg::OP_ALIGN;
                if (unit_ge) begin
                    n_rd = r_rd << 1;
                    n_ud = r_ud << 1;
                    n_k  = r_k + KW'(1);
                end else begin
                    n_state = mie_pkg::ST_SUB;
                end
            end
            mie_pkg::ST_SUB: begin
                op_sel = mie_pkg::OP_SUB;
                if (r_k != '0) begin
                    n_r0 = sub_r0;
                    n_u0 = sub_u0;
                    n_rd = r_rd >> 1;
                    n_ud = r_ud >> 1;
                    n_k  = r_k - KW'(1);
                end else begin
                    // Division done: shift the remainder sequence by one.
                    n_r0  = r_r1;
                    n_u0  = r_u1;
                    n_r1  = sub_r0;
                    n_u1  = sub_u0;
                    n_neg = ~r_neg;
                    n_rd  = sub_r0;
                    n_ud  = sub_u0;
                    if (sub_r0 == '0) begin
                        n_state = mie_pkg::ST_FIX;
                    end else begin
                        n_state = mie_pkg::ST_ALIGN;
                    end
                end
            end
            mie_pkg::ST_FIX: begin
                // Bring the coefficient magnitude below the modulus.
                op_sel = mie_pkg::OP_FIX;
                if (unit_ge) begin
                    n_u0 = unit_diff;
                end
                n_state = mie_pkg::ST_NEG;
            end
            mie_pkg::ST_NEG: begin
                // A negative coefficient maps to m minus its magnitude.
                op_sel  = mie_pkg::OP_NEG;
                n_ok    = gcd_one;
                n_valid = 1'b1;
                if (!gcd_one) begin
                    n_inv = '0;
                end else if (r_neg && (r_u0 != '0)) begin
                    n_inv = unit_diff;
                end else begin
                    n_inv = r_u0;
                end
                n_state = mie_pkg::ST_IDLE;
            end
            default: begin
                n_state = mie_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy           = (r_state != mie_pkg::ST_IDLE);
    assign o_valid          = r_valid;
    assign o_inverse        = r_inv;
    assign o_inverse_exists = r_ok;

    // The result strobe lasts a single cycle per item.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted item always makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not start the sequencer");

    // A valid inverse is always reduced below the modulus.
    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inverse_exists) |-> (o_inverse < r_mod))
        else $error("inverse not reduced below the modulus");

    // No inverse means a zero result.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inverse_exists) |-> (o_inverse == '0))
        else $error("nonzero result without an inverse");

    // The divisor is never zero while the long division runs.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mie_pkg::ST_ALIGN) || (r_state == mie_pkg::ST_SUB))
            |-> (r_rd != '0))
        else $error("division started with a zero divisor");

endmodule

`default_nettype wire
